>>> rtl/core/wqat_pkg.sv
// ----------------------------------------------------------------------------
// wqat_pkg
// Shared sizes and types for the weighted quorum ack tracker.
// ----------------------------------------------------------------------------
package wqat_pkg;

	localparam int NODES       = 64;
	localparam int IDX_W       = $clog2(NODES);
	localparam int WEIGHT_BITS = 16;
	localparam int ACK_W       = 64;
	localparam int QW_W        = 22;
	// weight sum over the whole table never overflows this width
	localparam int SUM_W       = IDX_W + WEIGHT_BITS;

	localparam int IN_W  = IDX_W + WEIGHT_BITS + ACK_W;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 1 + ACK_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// one node table entry
	typedef struct packed {
		logic [ACK_W-1:0]       ack;
		logic [WEIGHT_BITS-1:0] weight;
	} entry_t;

endpackage

>>> rtl/core/weighted_quorum_ack_tracker_unit.sv
// ----------------------------------------------------------------------------
// weighted_quorum_ack_tracker_unit
// Tracks per-node acks and stake weights; reports the quorum ack.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                    | contents
//  ---------+-----+--------------------------+-----------------------------------
//  reports  | in  | s_tvalid/s_tready/s_tdata| node_id, node_weight_in, ack_value
//  results  | out | m_tvalid/m_tready/m_tdata| accepted, quorum_ack; tuser: valid
//  config   | in  | cfg_wr_en/cfg_wr_data    | quorum_weight
//
//  A stale report goes from the lookup straight to its result. An accepted
//  report walks the distinct ack values from the top down, one pass over the
//  node memory per value. Each pass reads one entry per cycle through its
//  single read port, then closes through the drain, eval and check states.
//  Reset clears the seen bits and quorum state; quorum_weight resets to 1.
//  A result waiting on m_tready holds the unit in its final state.
// ----------------------------------------------------------------------------
module weighted_quorum_ack_tracker_unit
	import wqat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [5:0] node_id, [21:6] node_weight_in, [85:22] ack_value, rest zero
	input  logic [IN_TW-1:0]  s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [0] accepted, [64:1] quorum_ack, rest zero
	output logic [OUT_TW-1:0] m_tdata,
	// [0] quorum_valid
	output logic              m_tuser,
	input  logic              cfg_wr_en,
	input  logic [QW_W-1:0]   cfg_wr_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_EVAL   = 3'd4;
	localparam logic [2:0] ST_CHECK  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0]             state_q;
	logic [QW_W-1:0]        quorum_q;
	logic [NODES-1:0]       seen_q;
	entry_t                 mem [NODES];
	entry_t                 rd_q;
	logic [IDX_W-1:0]       rd_addr;
	logic                   rd_en;
	logic                   wr_en;

	logic [IDX_W-1:0]       id_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [ACK_W-1:0]       ack_q;
	logic                   acc_q;

	logic [IDX_W-1:0]       scan_idx_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   top_q;
	logic [ACK_W-1:0]       thr_q;
	logic                   cand_have_q;
	logic [ACK_W-1:0]       cand_max_q;
	logic [SUM_W-1:0]       cand_w_q;
	logic [SUM_W-1:0]       cum_q;
	logic                   found_q;
	logic [ACK_W-1:0]       qv_q;

	logic                   m_tvalid_q;
	logic                   out_acc_q;
	logic                   out_valid_q;
	logic [ACK_W-1:0]       out_ack_q;

	logic                   s_xfer;
	logic                   out_free;
	logic                   stale;
	logic                   take;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign stale    = seen_q[id_q] && !(ack_q > rd_q.ack);
	assign wr_en    = (state_q == ST_LOOK) && !stale;
	assign rd_en    = s_xfer || (state_q == ST_SCAN);
	assign rd_addr  = (state_q == ST_SCAN) ? scan_idx_q : s_tdata[IDX_W-1:0];
	// entry takes part in this pass if seen and, after the first pass, below the last walked value
	assign take     = valid_s1 && seen_q[idx_s1] && (top_q || rd_q.ack < thr_q);

	// hold the quorum weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quorum_q <= QW_W'(1);
		end else if (cfg_wr_en) begin
			quorum_q <= cfg_wr_data;
		end
	end

	// node table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[id_q] <= '{ack: ack_q, weight: w_q};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// latch the report on transfer
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			id_q  <= s_tdata[IDX_W-1:0];
			w_q   <= s_tdata[IDX_W +: WEIGHT_BITS];
			ack_q <= s_tdata[IDX_W+WEIGHT_BITS +: ACK_W];
		end
	end

	// track the scan pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			idx_s1   <= scan_idx_q;
		end
	end

	// find the next lower distinct ack and the weight of the nodes holding it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_have_q <= 1'b0;
			cand_max_q  <= '0;
			cand_w_q    <= '0;
		end else if (state_q == ST_CHECK) begin
			cand_have_q <= 1'b0;
		end else if (take) begin
			if (!cand_have_q || rd_q.ack > cand_max_q) begin
				cand_have_q <= 1'b1;
				cand_max_q  <= rd_q.ack;
				cand_w_q    <= SUM_W'(rd_q.weight);
			end else if (rd_q.ack == cand_max_q) begin
				cand_w_q <= SUM_W'(cand_w_q + SUM_W'(rd_q.weight));
			end
		end
	end

	// sequence the lookup, update and descending walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seen_q     <= '0;
			acc_q      <= 1'b0;
			scan_idx_q <= '0;
			top_q      <= 1'b1;
			thr_q      <= '0;
			cum_q      <= '0;
			found_q    <= 1'b0;
			qv_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (stale) begin
						acc_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						seen_q[id_q] <= 1'b1;
						acc_q        <= 1'b1;
						top_q        <= 1'b1;
						cum_q        <= '0;
						scan_idx_q   <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= IDX_W'(scan_idx_q + 1'b1);
					if (scan_idx_q == IDX_W'(NODES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					cum_q   <= SUM_W'(cum_q + cand_w_q);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!cand_have_q) begin
						state_q <= ST_FINISH;
					end else if (found_q && cand_max_q <= qv_q) begin
						state_q <= ST_FINISH;
					end else if (cum_q >= SUM_W'(quorum_q)) begin
						qv_q    <= cand_max_q;
						found_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						thr_q      <= cand_max_q;
						top_q      <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q  <= 1'b0;
			out_acc_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_ack_q   <= '0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q  <= 1'b1;
			out_acc_q   <= acc_q;
			out_valid_q <= found_q;
			out_ack_q   <= found_q ? qv_q : '0;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_valid_q;
	assign m_tdata  = OUT_TW'({out_ack_q, out_acc_q});

endmodule

>>> dv/tb_weighted_quorum_ack_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_weighted_quorum_ack_tracker_unit
// Self-checking bench for the weighted quorum ack tracker. Node reports go in
// over the slave stream. Each transfer updates a local node table that
// predicts the accepted flag and the quorum ack. Results on the master stream
// are checked in order against those predictions. The quorum weight steps
// through several settings, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_weighted_quorum_ack_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import wqat_pkg::*;

	localparam int RX_HOLD_CYCLES = 600;
	localparam int IDLE_GAP       = 8;
	localparam int HOT_LO         = 3;
	localparam int HOT_N          = 16;
	localparam int PHASE_ITEMS    = 100;
	localparam int PHASES         = 7;
	localparam logic [QW_W-1:0] QW_MAX = '1;

	typedef struct {
		logic [IDX_W-1:0]       id;
		logic [WEIGHT_BITS-1:0] weight;
		logic [ACK_W-1:0]       ack;
	} node_report_t;

	typedef struct {
		logic             accepted;
		logic             valid;
		logic [ACK_W-1:0] ack;
	} quorum_status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;
	logic              m_tuser;
	logic              cfg_wr_en = 1'b0;
	logic [QW_W-1:0]   cfg_wr_data = '0;

	// predicted node table and quorum state
	logic                   tbl_seen   [NODES] = '{default: 1'b0};
	logic [ACK_W-1:0]       tbl_ack    [NODES];
	logic [WEIGHT_BITS-1:0] tbl_weight [NODES];
	logic                   q_found = 1'b0;
	logic [ACK_W-1:0]       q_value = '0;
	logic [QW_W-1:0]        quorum_need = 1;

	// stimulus-side view of what each node has reported so far
	logic                   gen_seen [NODES] = '{default: 1'b0};
	logic [ACK_W-1:0]       gen_ack  [NODES];
	logic [WEIGHT_BITS-1:0] gen_w    [NODES];

	node_report_t   report_q[$];
	quorum_status_t expected_status_q[$];

	logic in_taken = 1'b0;
	logic gaps_on = 1'b1;
	int   rx_hold_asked = 0;
	int   rx_hold_done = 0;
	int   rx_hold_left = 0;
	int   n_queued = 0;
	int   n_taken = 0;
	int   n_raised = 0;
	int   n_stale = 0;
	int   n_advances = 0;
	int   n_settings = 0;
	int   mismatch_cnt = 0;

	weighted_quorum_ack_tracker_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// print one mismatch line and count it
	task automatic flag_mismatch(input string what, input logic [ACK_W-1:0] got,
			input logic [ACK_W-1:0] want);
		mismatch_cnt++;
		$display("%t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
	endtask

	// summed weight of seen nodes whose ack is at least floor_ack
	function automatic logic [31:0] stake_at_or_above(input logic [ACK_W-1:0] floor_ack);
		logic [31:0] sum;
		sum = '0;
		for (int i = 0; i < NODES; i++)
			if (tbl_seen[i] && tbl_ack[i] >= floor_ack)
				sum += tbl_weight[i];
		return sum;
	endfunction

	// apply one report to the table and return the status it should produce
	function automatic quorum_status_t quorum_after_report(input node_report_t rep);
		quorum_status_t st;
		logic           raised;
		logic           have;
		logic [ACK_W-1:0] best;
		raised = !tbl_seen[rep.id] || rep.ack > tbl_ack[rep.id];
		if (raised) begin
			tbl_seen[rep.id]   = 1'b1;
			tbl_ack[rep.id]    = rep.ack;
			tbl_weight[rep.id] = rep.weight;
			have = 1'b0;
			best = '0;
			// largest stored ack whose weight at or above reaches the quorum
			for (int i = 0; i < NODES; i++)
				if (tbl_seen[i] && (!have || tbl_ack[i] > best)
						&& stake_at_or_above(tbl_ack[i]) >= quorum_need) begin
					best = tbl_ack[i];
					have = 1'b1;
				end
			// the quorum ack only moves up
			if (have && (!q_found || best > q_value)) begin
				q_value = best;
				q_found = 1'b1;
				n_advances++;
			end
			n_raised++;
		end else begin
			n_stale++;
		end
		st.accepted = raised;
		st.valid    = q_found;
		st.ack      = q_found ? q_value : '0;
		return st;
	endfunction

	// check each result transfer, then predict each report transfer
	always @(posedge clk) begin
		quorum_status_t got;
		quorum_status_t want;
		node_report_t   rep;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.valid    = m_tuser;
				got.ack      = m_tdata[ACK_W:1];
				if (expected_status_q.size() == 0) begin
					flag_mismatch("unexpected result", got.ack, '0);
				end else begin
					want = expected_status_q.pop_front();
					if (got.accepted !== want.accepted)
						flag_mismatch("accepted", ACK_W'(got.accepted),
							ACK_W'(want.accepted));
					if (got.valid !== want.valid)
						flag_mismatch("quorum_valid", ACK_W'(got.valid),
							ACK_W'(want.valid));
					if (got.ack !== want.ack)
						flag_mismatch("quorum_ack", got.ack, want.ack);
				end
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				rep.id     = s_tdata[IDX_W-1:0];
				rep.weight = s_tdata[IDX_W +: WEIGHT_BITS];
				rep.ack    = s_tdata[IDX_W + WEIGHT_BITS +: ACK_W];
				expected_status_q.push_back(quorum_after_report(rep));
				n_taken++;
			end
		end
	end

	// offer queued reports; hold each until its transfer
	always @(negedge clk) begin
		node_report_t rep;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (report_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 31)) begin
				rep = report_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(IN_TW - IN_W){1'b0}}, rep.ack, rep.weight, rep.id};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side ready: random stalls plus a long requested hold-off
	always @(negedge clk) begin
		if (rx_hold_done != rx_hold_asked) begin
			rx_hold_done = rx_hold_asked;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(gaps_on && $urandom_range(0, 99) < 31);
		end
	end

	task automatic queue_report(input logic [IDX_W-1:0] id, input logic [WEIGHT_BITS-1:0] w,
			input logic [ACK_W-1:0] a);
		node_report_t rep;
		rep.id     = id;
		rep.weight = w;
		rep.ack    = a;
		report_q.push_back(rep);
		n_queued++;
		if (!gen_seen[id] || a > gen_ack[id]) begin
			gen_seen[id] = 1'b1;
			gen_ack[id]  = a;
			gen_w[id]    = w;
		end
	endtask

	// wait until every report is through and every result has come back
	task automatic wait_idle();
		while (n_taken != n_queued || expected_status_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_quorum(input logic [QW_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		quorum_need = v;
		n_settings++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly rising acks on a hot node set, with stale repeats and noise
	task automatic queue_random_reports(input int count);
		logic [IDX_W-1:0]       id;
		logic [WEIGHT_BITS-1:0] w;
		logic [ACK_W-1:0]       a;
		int                     pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				id = IDX_W'(HOT_LO + $urandom_range(0, HOT_N - 1));
				a  = gen_ack[id] + (($urandom_range(0, 9) == 0) ? $urandom
					: $urandom_range(1, 500));
				w  = ($urandom_range(0, 19) == 0) ? WEIGHT_BITS'($urandom) : gen_w[id];
			end else if (pick < 78) begin
				id = IDX_W'(HOT_LO + $urandom_range(0, HOT_N - 1));
				a  = gen_ack[id] - $urandom_range(0, 3);
				w  = WEIGHT_BITS'($urandom);
			end else if (pick < 96) begin
				id = IDX_W'($urandom_range(0, NODES - 1));
				a  = gen_ack[id] + $urandom_range(1, 1 << 20);
				w  = gen_w[id];
			end else begin
				id = IDX_W'($urandom);
				w  = WEIGHT_BITS'($urandom);
				a  = {$urandom, $urandom};
			end
			queue_report(id, w, a);
		end
	endtask

	initial begin
		logic [QW_W-1:0]  phase_quorum [PHASES];
		logic [ACK_W-1:0] base;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: weightless first report, stale repeats, zero quorum weight
		queue_report(0, 16'h0000, 64'd5);
		queue_report(0, 16'h0000, 64'd5);
		queue_report(0, 16'h0000, 64'd3);
		write_quorum('0);
		queue_report(63, 16'hFFFF, 64'd0);
		// unreachable quorum; top ack value on a weightless node
		write_quorum(QW_MAX);
		queue_report(1, 16'h0000, '1);
		queue_report(1, 16'hFFFF, '1);
		// quorum built from two nodes, then a weight change that loses it
		write_quorum(50000);
		queue_report(42, 16'hAAAA, 64'd6);
		queue_report(21, 16'h5555, 64'd7);
		queue_report(21, 16'd100, 64'd8);
		queue_report(21, 16'h5555, 64'd8);
		queue_report(42, 16'hAAAA, 64'd9);
		queue_report(2, 16'hFFFF, 64'd10);

		// seed unreported nodes: hot set near one base, others scattered
		base = {8'h00, 24'($urandom), $urandom};
		for (int i = 0; i < NODES; i++)
			if (!gen_seen[i]) begin
				if (i >= HOT_LO && i < HOT_LO + HOT_N) begin
					gen_ack[i] = base + $urandom_range(0, 100000);
					gen_w[i]   = WEIGHT_BITS'($urandom_range(0, 8000));
				end else begin
					gen_ack[i] = {$urandom, $urandom} >> $urandom_range(1, 63);
					gen_w[i]   = WEIGHT_BITS'($urandom_range(0, 3000));
				end
			end

		// random phases, quorum weight mostly falling so the quorum keeps moving
		phase_quorum = '{QW_MAX, 60000, 20000, 5000,
			QW_W'($urandom_range(0, 4194303)), 1, 0};
		for (int p = 0; p < PHASES; p++) begin
			write_quorum(phase_quorum[p]);
			gaps_on = (p != 2);
			queue_random_reports(PHASE_ITEMS);
			if (p == 1)
				rx_hold_asked++;
		end
		wait_idle();

		$display("Covered %0d reports (%0d raised an ack, %0d stale) over %0d quorum settings",
			n_taken, n_raised, n_stale, n_settings);
		$display("Quorum ack moved up %0d times; %0d mismatches", n_advances, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_status_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hard stop for a hung handshake
	initial begin
		#250_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
